// ===== sv/givens_rotation_generator_core_macros.svh =====
// Assertion macros used by the rotation generator top level.
`ifndef GIVENS_ROTATION_GENERATOR_CORE_MACROS_SVH
`define GIVENS_ROTATION_GENERATOR_CORE_MACROS_SVH

// Implication checked on every rising clock edge outside reset.
`define GRG_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication outside reset.
`define GRG_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== sv/grg_pkg.sv =====
// Package for the rotation generator: default width constants.
package grg_pkg;
  localparam int unsigned ValueWidthDef = 32;
  localparam int unsigned FractionBitsDef = 30;
endpackage

// ===== sv/grg_div_stage.sv =====
// One restoring-division step of the fraction divider pipeline.
module grg_div_stage
  import grg_pkg::*;
#(
  parameter int unsigned MagWidth = ValueWidthDef,
  parameter int unsigned QuoWidth = FractionBitsDef + 1
) (
  input  logic [MagWidth-1:0] rem_i,
  input  logic [MagWidth-1:0] den_i,
  input  logic [QuoWidth-1:0] quo_i,
  output logic [MagWidth-1:0] rem_o,
  output logic [QuoWidth-1:0] quo_o
);
  logic [MagWidth:0] diff;
  logic              take;

  always_comb begin
    // r >= den - r  <=>  2r >= den
    diff  = {rem_i, 1'b0} - {1'b0, den_i};
    take  = ({rem_i, 1'b0} >= {1'b0, den_i});
    rem_o = take ? diff[MagWidth-1:0] : {rem_i[MagWidth-2:0], 1'b0};
    quo_o = {quo_i[QuoWidth-2:0], take};
  end
endmodule

// ===== sv/grg_rsqrt_stage.sv =====
// One bit decision of the reciprocal square root search.
module grg_rsqrt_stage
  import grg_pkg::*;
#(
  parameter int unsigned FracBits = FractionBitsDef,
  parameter int unsigned Bit      = 0
) (
  input  logic [FracBits:0]     y_i,
  input  logic [FracBits+1:0]   w_i,
  input  logic [3*FracBits+3:0] p_i,  // y*y*w so far
  input  logic [3*FracBits+3:0] q_i,  // y*w so far
  output logic [FracBits:0]     y_o,
  output logic [3*FracBits+3:0] p_o,
  output logic [3*FracBits+3:0] q_o
);
  localparam int unsigned ProdW = 3 * FracBits + 4;
  logic [FracBits:0] cand;
  logic [ProdW-1:0]  wide_w;
  logic [ProdW-1:0]  trial;
  logic              take;

  always_comb begin
    cand   = y_i | ((FracBits+1)'(1) << Bit);
    wide_w = ProdW'(w_i);
    // (y + 2^Bit)^2 * w = y*y*w + (y*w << (Bit+1)) + (w << 2*Bit)
    trial  = p_i + (q_i << (Bit + 1)) + (wide_w << (2 * Bit));
    take   = (trial <= (ProdW'(1) << (3 * FracBits)));
    y_o    = take ? cand : y_i;
    p_o    = take ? trial : p_i;
    q_o    = take ? (q_i + (wide_w << Bit)) : q_i;
  end
endmodule

// ===== sv/givens_rotation_generator_core.sv =====
// Givens rotation generator top level: pipelined divide, square, rsqrt, scale.
// Accepts one (a, b) transfer per clock and returns (c, s) in Q2.FRACTION_BITS
// through a register pipeline: one register per divider quotient bit, one per
// reciprocal square root bit, plus entry, square, scale and output registers.
// Throughput is one transfer per cycle; a stall on the output freezes the whole
// pipeline, and in_ready_o follows the output side so nothing is lost or repeated.
`include "givens_rotation_generator_core_macros.svh"
module givens_rotation_generator_core
  import grg_pkg::*;
#(
  parameter int unsigned VALUE_WIDTH   = ValueWidthDef,
  parameter int unsigned FRACTION_BITS = FractionBitsDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic signed [VALUE_WIDTH-1:0] first_value_i,
  input  logic signed [VALUE_WIDTH-1:0] second_value_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic signed [VALUE_WIDTH-1:0] cosine_o,
  output logic signed [VALUE_WIDTH-1:0] sine_o
);
  localparam int unsigned F    = FRACTION_BITS;
  localparam int unsigned MW   = VALUE_WIDTH;   // magnitude width (holds 2^(W-1))
  localparam int unsigned QW   = F + 1;         // t magnitude, up to 1.0
  localparam int unsigned DS   = F;             // divider steps
  localparam int unsigned RS   = F + 1;         // rsqrt bits F..0
  localparam int unsigned PW   = 3 * F + 4;     // running y*y*w and y*w
  localparam int unsigned NST  = 1 + DS + 1 + RS + 2;

  // Whole pipeline advances together; the last stage is the output register.
  logic adv;
  logic [NST-1:0] vld_q, vld_d;
  assign adv        = !vld_q[NST-1] || out_ready_i;
  assign in_ready_o = adv;

  always_comb begin
    vld_d = {vld_q[NST-2:0], in_valid_i};
  end
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (adv) begin
      vld_q <= vld_d;
    end
  end

  // Flags per item: zero-b, big-b, t negative.
  typedef struct packed {
    logic zb;
    logic bigb;
    logic tneg;
  } flags_t;

  // ---- entry stage: magnitudes and selection
  logic [MW-1:0] ma, mb;
  logic          na, nb;
  always_comb begin
    na = first_value_i[MW-1];
    nb = second_value_i[MW-1];
    ma = na ? MW'(-first_value_i) : MW'(first_value_i);
    mb = nb ? MW'(-second_value_i) : MW'(second_value_i);
  end

  flags_t        fl_q [NST];
  logic [MW-1:0] rem_q [DS+1];
  logic [MW-1:0] den_q [DS+1];
  logic [QW-1:0] quo_q [DS+1];

  always_ff @(posedge clk_i) begin
    if (adv) begin
      fl_q[0].zb   <= (mb == '0);
      fl_q[0].bigb <= (mb > ma);
      fl_q[0].tneg <= (na == nb);
      if (mb > ma) begin
        rem_q[0] <= ma;
        den_q[0] <= mb;
        quo_q[0] <= '0;
      end else if (mb == ma) begin
        // num == den: quotient is exactly 1.0; zero divisor is ignored later
        rem_q[0] <= '0;
        den_q[0] <= '1;
        quo_q[0] <= QW'(1);
      end else begin
        rem_q[0] <= mb;
        den_q[0] <= ma;
        quo_q[0] <= '0;
      end
    end
  end

  // ---- divider: one quotient bit per stage
  for (genvar i = 0; i < DS; i++) begin : g_div
    logic [MW-1:0] rem_n;
    logic [QW-1:0] quo_n;
    grg_div_stage #(.MagWidth(MW), .QuoWidth(QW)) u_div (
      .rem_i(rem_q[i]), .den_i(den_q[i]), .quo_i(quo_q[i]),
      .rem_o(rem_n), .quo_o(quo_n)
    );
    always_ff @(posedge clk_i) begin
      if (adv) begin
        rem_q[i+1] <= rem_n;
        den_q[i+1] <= den_q[i];
        quo_q[i+1] <= quo_n;
        fl_q[i+1]  <= fl_q[i];
      end
    end
  end

  // ---- square stage: w = 1.0 + (t*t >> F); t = 1.0 gives w = 2.0
  logic [2*QW-1:0] tsq;
  logic [F+1:0]    w_q [RS+1];
  logic [F:0]      y_q [RS+1];
  logic [PW-1:0]   p_q [RS+1];
  logic [PW-1:0]   q_q [RS+1];
  logic [QW-1:0]   tm_q [RS+1];
  assign tsq = quo_q[DS] * quo_q[DS];
  always_ff @(posedge clk_i) begin
    if (adv) begin
      w_q[0]  <= ((F+2)'(1) << F) + (F+2)'(tsq >> F);
      y_q[0]  <= '0;
      p_q[0]  <= '0;
      q_q[0]  <= '0;
      tm_q[0] <= quo_q[DS];
      fl_q[DS+1] <= fl_q[DS];
    end
  end

  // ---- reciprocal square root: one bit per stage, MSB first, shift and add
  for (genvar k = 0; k < RS; k++) begin : g_rs
    logic [F:0]    y_n;
    logic [PW-1:0] p_n, q_n;
    grg_rsqrt_stage #(.FracBits(F), .Bit(F - k)) u_rs (
      .y_i(y_q[k]), .w_i(w_q[k]), .p_i(p_q[k]), .q_i(q_q[k]),
      .y_o(y_n), .p_o(p_n), .q_o(q_n)
    );
    always_ff @(posedge clk_i) begin
      if (adv) begin
        y_q[k+1]   <= y_n;
        p_q[k+1]   <= p_n;
        q_q[k+1]   <= q_n;
        w_q[k+1]   <= w_q[k];
        tm_q[k+1]  <= tm_q[k];
        fl_q[DS+2+k] <= fl_q[DS+1+k];
      end
    end
  end

  // ---- scale stage: other = r*|t| >> F
  logic [2*QW-1:0] prod;
  logic [F:0]      r_q, oth_q;
  assign prod = y_q[RS] * tm_q[RS];
  always_ff @(posedge clk_i) begin
    if (adv) begin
      r_q   <= y_q[RS];
      oth_q <= (F+1)'(prod >> F);
      fl_q[NST-2] <= fl_q[NST-3];
    end
  end

  // ---- output register: signs and branch assignment
  logic [MW-1:0] cmag, smag;
  logic          cneg, sneg;
  logic signed [VALUE_WIDTH-1:0] cos_q, sin_q;
  always_comb begin
    cneg = 1'b0;
    sneg = 1'b0;
    if (fl_q[NST-2].zb) begin
      cmag = MW'(1) << F;
      smag = '0;
    end else if (fl_q[NST-2].bigb) begin
      smag = MW'(r_q);
      cmag = MW'(oth_q);
      cneg = fl_q[NST-2].tneg;
    end else begin
      cmag = MW'(r_q);
      smag = MW'(oth_q);
      sneg = fl_q[NST-2].tneg;
    end
  end
  always_ff @(posedge clk_i) begin
    if (adv) begin
      cos_q <= cneg ? -cmag : cmag;
      sin_q <= sneg ? -smag : smag;
      fl_q[NST-1] <= fl_q[NST-2];
    end
  end

  assign out_valid_o = vld_q[NST-1];
  assign cosine_o    = cos_q;
  assign sine_o      = sin_q;

  `GRG_ASSERT_NEXT(a_stall_holds, out_valid_o && !out_ready_i, out_valid_o,
    "result lost during stall")
  `GRG_ASSERT_IMP(a_ready_follows, out_valid_o && !out_ready_i, !in_ready_o,
    "input accepted while pipeline frozen")
  `GRG_ASSERT_NEXT(a_zero_b, adv && vld_q[NST-2] && fl_q[NST-2].zb,
    sine_o == '0, "nonzero sine for zero b")
endmodule

// ===== tb/givens_rotation_generator_core_test.sv =====
// Self-checking testbench for the Givens rotation generator core.
`timescale 1ns / 1ps
module givens_rotation_generator_core_test;
  import grg_pkg::*;

  localparam int VW = ValueWidthDef;
  localparam int FB = FractionBitsDef;
  // Pipeline depth: the number of register stages in the top level.
  localparam int PIPE_DEPTH = 2 * FB + 5;
  localparam int STALL_LIMIT = 20000;
  localparam int N_RANDOM = 400;
  localparam logic [VW-1:0] ONE_Q = 32'sd1 << FB;
  // 1/sqrt(2) truncated to 30 fraction bits.
  localparam logic [VW-1:0] HALF_ROOT2 = 32'd759250124;

  typedef struct packed {
    logic [VW-1:0] a;
    logic [VW-1:0] b;
    logic          has_exp;
    logic [VW-1:0] cos_exp;
    logic [VW-1:0] sin_exp;
  } dir_row_t;

  typedef struct packed {
    logic [VW-1:0] cos_v;
    logic [VW-1:0] sin_v;
  } rotation_t;

  logic clk_i, rst_ni;
  logic in_valid_i, in_ready_o, out_valid_o, out_ready_i;
  logic signed [VW-1:0] first_value_i, second_value_i, cosine_o, sine_o;

  rotation_t pending_rotations[$];
  int errors;
  int idle_cycles;
  int send_idle_pct, recv_stall_pct;

  givens_rotation_generator_core i_dut (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .first_value_i, .second_value_i,
    .out_valid_o, .out_ready_i, .cosine_o, .sine_o
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // floor(num * 2^FB / den), num <= den
  function automatic logic [63:0] q_ratio(logic [63:0] num, logic [63:0] den);
    logic [127:0] n;
    if (num >= den) return 64'd1 << FB;
    n = {64'd0, num} << FB;
    return 64'(n / den);
  endfunction

  function automatic logic [63:0] q_mul(logic [63:0] x, logic [63:0] y);
    logic [127:0] p;
    p = x * y;
    return 64'(p >> FB);
  endfunction

  // largest y <= 2^FB with y*y*w <= 2^(3*FB)
  function automatic logic [63:0] q_rsqrt(logic [63:0] w);
    logic [191:0] prod, target;
    logic [63:0] y, cand;
    y = 0;
    target = 192'd1 << (3 * FB);
    for (int bit_i = FB; bit_i >= 0; bit_i--) begin
      cand = y | (64'd1 << bit_i);
      prod = 192'(cand) * 192'(cand) * 192'(w);
      if (prod <= target) y = cand;
    end
    return y;
  endfunction

  function automatic rotation_t rotation_for(logic [VW-1:0] a, logic [VW-1:0] b);
    rotation_t res;
    logic [63:0] ma, mb, tm, r, other, cmag, smag;
    logic na, nb, tneg, big_b, cneg, sneg;
    na = a[VW-1];
    nb = b[VW-1];
    ma = na ? 64'(-a) & 64'hFFFF_FFFF : 64'(a);
    mb = nb ? 64'(-b) & 64'hFFFF_FFFF : 64'(b);
    cneg = 1'b0;
    sneg = 1'b0;
    if (mb == 0) begin
      cmag = 64'd1 << FB;
      smag = 0;
    end else begin
      big_b = mb > ma;
      tm = big_b ? q_ratio(ma, mb) : q_ratio(mb, ma);
      tneg = (na == nb);
      r = q_rsqrt((64'd1 << FB) + q_mul(tm, tm));
      other = q_mul(r, tm);
      if (big_b) begin
        smag = r; cmag = other; cneg = tneg;
      end else begin
        cmag = r; smag = other; sneg = tneg;
      end
    end
    res.cos_v = VW'(cneg ? -cmag : cmag);
    res.sin_v = VW'(sneg ? -smag : smag);
    return res;
  endfunction

  // Called at a falling edge; returns at the falling edge after the transfer
  // with valid still high, so a following call can drive back to back.
  task automatic send_pair(logic [VW-1:0] a, logic [VW-1:0] b,
                           logic has_exp, rotation_t typed);
    rotation_t pred;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    pred = rotation_for(a, b);
    if (has_exp && pred != typed) begin
      $error("typed-in rotation differs from predictor for a=%h b=%h", a, b);
      errors++;
    end
    pending_rotations.push_back(has_exp ? typed : pred);
    in_valid_i <= 1'b1;
    first_value_i <= a;
    second_value_i <= b;
    do @(posedge clk_i); while (!in_ready_o);
    @(negedge clk_i);
  endtask

  task automatic wait_drain();
    while (pending_rotations.size() != 0) @(negedge clk_i);
  endtask

  function automatic logic [VW-1:0] rand_value();
    case ($urandom_range(5))
      0: return VW'($urandom_range(255)) - VW'(128);
      1: return VW'({1'b1, VW'(0)} >> $urandom_range(VW));
      2: return VW'($urandom) >> $urandom_range(VW - 1);
      default: return VW'($urandom);
    endcase
  endfunction

  // Receiver side and checking.
  always @(posedge clk_i) begin
    rotation_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_rotations.size() == 0) begin
        $error("rotation output with nothing expected");
        errors++;
      end else begin
        want = pending_rotations.pop_front();
        if (cosine_o !== want.cos_v) begin
          $error("cosine: expected %h, got %h", want.cos_v, cosine_o);
          errors++;
        end
        if (sine_o !== want.sin_v) begin
          $error("sine: expected %h, got %h", want.sin_v, sine_o);
          errors++;
        end
      end
    end
  end

  always @(negedge clk_i) begin
    out_ready_i <= ($urandom_range(99) >= recv_stall_pct);
  end

  // Watchdog on cycles without any transfer.
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      idle_cycles <= 0;
    end else if (pending_rotations.size() != 0) begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("givens_rotation_generator_core_test failed");
        $finish;
      end
    end
  end

  initial begin
    dir_row_t dir_rows[$];
    rotation_t typed;
    logic [VW-1:0] a, b, mn;
    mn = {1'b1, {(VW - 1){1'b0}}};
    errors = 0;
    idle_cycles = 0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    out_ready_i = 1'b1;
    first_value_i = '0;
    second_value_i = '0;
    // a, b, typed?, cosine, sine
    dir_rows = '{
      '{32'd0, 32'd0, 1'b1, ONE_Q, 32'd0},                // both zero
      '{32'd5, 32'd0, 1'b1, ONE_Q, 32'd0},
      '{mn, 32'd0, 1'b1, ONE_Q, 32'd0},
      '{32'd0, 32'd7, 1'b1, 32'd0, ONE_Q},                // first zero
      '{32'd0, mn, 1'b1, 32'd0, ONE_Q},
      '{32'd0, 32'hFFFF_FFFF, 1'b1, 32'd0, ONE_Q},
      '{32'd3, 32'd3, 1'b1, HALF_ROOT2, -HALF_ROOT2},     // equal magnitudes
      '{32'd3, -32'd3, 1'b1, HALF_ROOT2, HALF_ROOT2},
      '{mn, mn, 1'b1, HALF_ROOT2, -HALF_ROOT2},           // most negative
      '{32'h7FFF_FFFF, mn, 1'b0, 32'd0, 32'd0},
      '{mn, 32'h7FFF_FFFF, 1'b0, 32'd0, 32'd0},
      '{32'h7FFF_FFFF, 32'd1, 1'b0, 32'd0, 32'd0},
      '{32'd1, 32'h7FFF_FFFF, 1'b0, 32'd0, 32'd0},
      '{32'hFFFF_FFFF, 32'd1, 1'b0, 32'd0, 32'd0},
      '{32'd3, 32'd4, 1'b0, 32'd0, 32'd0},
      '{-32'd4, 32'd3, 1'b0, 32'd0, 32'd0},
      '{32'h7FFF_FFFF, 32'h7FFF_FFFE, 1'b0, 32'd0, 32'd0},
      '{32'h5555_5555, 32'hAAAA_AAAA, 1'b0, 32'd0, 32'd0}
    };
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    foreach (dir_rows[i]) begin
      typed.cos_v = dir_rows[i].cos_exp;
      typed.sin_v = dir_rows[i].sin_exp;
      send_pair(dir_rows[i].a, dir_rows[i].b, dir_rows[i].has_exp, typed);
    end
    // Hold off until the pipeline has drained completely.
    in_valid_i <= 1'b0;
    wait_drain();
    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 52; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 52; end
        default: begin send_idle_pct = 17; recv_stall_pct = 17; end
      endcase
      for (int n = 0; n < N_RANDOM / 4; n++) begin
        a = rand_value();
        b = rand_value();
        send_pair(a, b, 1'b0, typed);
      end
    end
    in_valid_i <= 1'b0;
    recv_stall_pct = 0;
    wait_drain();
    repeat (PIPE_DEPTH + 10) @(posedge clk_i);
    if (errors == 0) begin
      $display("givens_rotation_generator_core_test passed");
    end else begin
      $display("givens_rotation_generator_core_test failed");
    end
    $finish;
  end
endmodule
